// ===== src/tlr_pkg.sv =====
// Shared constants, register codes and control types for the three-axis ramp.
`default_nettype none
package tlr_pkg;

	// Q8.16 axis values and frame counts
	localparam int VALUE_BITS = 24;
	localparam int FRAME_BITS = 12;
	localparam int AXES       = 3;

	// serial divider: magnitude of (target - value) needs one bit more than a value
	localparam int DIV_BITS = VALUE_BITS + 1;
	localparam int CNT_BITS = $clog2(DIV_BITS);

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = VALUE_BITS;

	localparam logic [VALUE_BITS-1:0] VAL_ONE      = VALUE_BITS'(64'h10000);
	localparam logic [VALUE_BITS-1:0] VAL_MAX      = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VAL_MIN      = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [DIV_BITS-1:0]   VAL_MAX_MAG  = {2'b00, {(VALUE_BITS-1){1'b1}}};
	localparam logic [DIV_BITS-1:0]   VAL_MIN_MAG  = {2'b01, {(VALUE_BITS-1){1'b0}}};
	localparam logic [FRAME_BITS-1:0] FRAMES_RESET = FRAME_BITS'(1);

	// register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TARGET_X = 3'd0,
		REG_TARGET_Y = 3'd1,
		REG_TARGET_Z = 3'd2,
		REG_FRAMES_X = 3'd3,
		REG_FRAMES_Y = 3'd4,
		REG_FRAMES_Z = 3'd5
	} tlr_reg_t;

	// sequencer strobes to every lane
	typedef struct packed {
		logic accept;
		logic prep;
		logic run;
		logic step;
		logic apply;
	} tlr_ctl_t;

endpackage
`default_nettype wire

// ===== src/tlr_div.sv =====
// Restoring serial divider, one quotient bit per cycle while run is high, unsigned magnitudes.
`default_nettype none
module tlr_div (
	input  wire logic                           clk,
	input  wire logic                           load,
	input  wire logic                           run,
	input  wire logic [tlr_pkg::DIV_BITS-1:0]   dividend,
	input  wire logic [tlr_pkg::FRAME_BITS-1:0] divisor,
	output logic      [tlr_pkg::DIV_BITS-1:0]   quotient
);

	logic [tlr_pkg::FRAME_BITS-1:0] rem_q;
	logic [tlr_pkg::DIV_BITS-1:0]   dq_q;
	logic [tlr_pkg::FRAME_BITS:0]   shifted;
	logic [tlr_pkg::FRAME_BITS:0]   diff;
	logic                           fits;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		shifted = {rem_q, dq_q[tlr_pkg::DIV_BITS-1]};
		fits    = shifted >= {1'b0, divisor};
		diff    = fits ? (shifted - {1'b0, divisor}) : shifted;
	end

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (run) begin
			rem_q <= diff[tlr_pkg::FRAME_BITS-1:0];
			dq_q  <= {dq_q[tlr_pkg::DIV_BITS-2:0], fits};
		end
	end

	assign quotient = dq_q;

endmodule
`default_nettype wire

// ===== src/tlr_lane.sv =====
// One axis lane: value, step, latch and active state with its own divider.
`default_nettype none
module tlr_lane (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tlr_pkg::tlr_ctl_t                     ctl,
	input  wire logic                                  arm,
	input  wire logic                                  load,
	input  wire logic signed [tlr_pkg::VALUE_BITS-1:0] load_val,
	input  wire logic signed [tlr_pkg::VALUE_BITS-1:0] target,
	input  wire logic        [tlr_pkg::FRAME_BITS-1:0] frames,
	output logic signed      [tlr_pkg::VALUE_BITS-1:0] value,
	output logic                                       active,
	output logic                                       arrived
);

	localparam int VB = tlr_pkg::VALUE_BITS;
	localparam int DB = tlr_pkg::DIV_BITS;

	logic signed [VB-1:0] value_q;
	logic signed [VB-1:0] step_q;
	logic                 latched_q;
	logic                 active_q;
	logic                 arrived_q;
	logic [DB-1:0]        diff_mag_s2;
	logic                 diff_neg_s2;

	logic signed [DB-1:0] diff;
	logic [DB-1:0]        diff_mag;
	logic [DB-1:0]        q_mag;
	logic signed [VB-1:0] q_sat;
	logic signed [VB-1:0] step_new;
	logic [DB-1:0]        step_mag;
	logic signed [DB-1:0] sum;
	logic signed [VB-1:0] sum_sat;
	logic                 hit;

	// remaining distance, taken after the load
	always_comb begin
		diff     = {target[VB-1], target} - {value_q[VB-1], value_q};
		diff_mag = diff[DB-1] ? DB'(-diff) : DB'(diff);
	end

	tlr_div u_div (
		.clk      (clk),
		.load     (ctl.prep),
		.run      (ctl.run),
		.dividend (diff_mag),
		.divisor  (frames),
		.quotient (q_mag)
	);

	// signed, saturated quotient and the step chosen on a fresh latch
	always_comb begin
		if (!diff_neg_s2) begin
			q_sat = (q_mag > tlr_pkg::VAL_MAX_MAG) ? tlr_pkg::VAL_MAX : q_mag[VB-1:0];
		end else begin
			q_sat = (q_mag > tlr_pkg::VAL_MIN_MAG) ? tlr_pkg::VAL_MIN : -q_mag[VB-1:0];
		end
		step_new = step_q;
		if (!latched_q) begin
			if (active_q) begin
				if (frames != '0) begin
					step_new = q_sat;
				end
			end else begin
				step_new = '0;
			end
		end
	end

	// arrival test and saturated advance
	always_comb begin
		step_mag = step_q[VB-1] ? DB'(-{step_q[VB-1], step_q}) : DB'({1'b0, step_q});
		hit      = diff_mag_s2 <= step_mag;
		sum      = {value_q[VB-1], value_q} + {step_q[VB-1], step_q};
		if (sum[DB-1] != sum[DB-2]) begin
			sum_sat = sum[DB-1] ? tlr_pkg::VAL_MIN : tlr_pkg::VAL_MAX;
		end else begin
			sum_sat = sum[VB-1:0];
		end
	end

	// distance captured for the divider and the arrival test
	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			diff_mag_s2 <= diff_mag;
			diff_neg_s2 <= diff[DB-1];
		end
	end

	// axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q   <= tlr_pkg::VAL_ONE;
			step_q    <= '0;
			latched_q <= 1'b0;
			active_q  <= 1'b0;
			arrived_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				if (load) begin
					value_q <= load_val;
				end
				if (arm) begin
					active_q  <= 1'b1;
					latched_q <= 1'b0;
				end
			end
			if (ctl.step) begin
				step_q    <= step_new;
				latched_q <= 1'b1;
			end
			if (ctl.apply) begin
				arrived_q <= active_q && hit;
				if (active_q) begin
					if (hit) begin
						value_q  <= target;
						active_q <= 1'b0;
					end else begin
						value_q <= sum_sat;
					end
				end
			end
		end
	end

	assign value   = value_q;
	assign active  = active_q;
	assign arrived = arrived_q;

endmodule
`default_nettype wire

// ===== src/tlr_merge.sv =====
// Output stage: gathers the lane results into one registered result word.
`default_nettype none
module tlr_merge (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	input  wire logic                                                 load,
	input  wire logic [tlr_pkg::AXES-1:0][tlr_pkg::VALUE_BITS-1:0]    lane_value,
	input  wire logic [tlr_pkg::AXES-1:0]                             lane_active,
	input  wire logic [tlr_pkg::AXES-1:0]                             lane_arrived,
	input  wire logic                                                 out_stall,
	output logic                                                      free,
	output logic                                                      out_valid,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]                     value_x,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]                     value_y,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]                     value_z,
	output logic [tlr_pkg::AXES-1:0]                                  active_mask,
	output logic [tlr_pkg::AXES-1:0]                                  arrived_mask
);

	logic                                              valid_q;
	logic [tlr_pkg::AXES-1:0][tlr_pkg::VALUE_BITS-1:0] value_q;
	logic [tlr_pkg::AXES-1:0]                          active_q;
	logic [tlr_pkg::AXES-1:0]                          arrived_q;

	// slot is free when empty or being taken now
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q   <= lane_value;
			active_q  <= lane_active;
			arrived_q <= lane_arrived;
		end
	end

	assign out_valid    = valid_q;
	assign value_x      = value_q[0];
	assign value_y      = value_q[1];
	assign value_z      = value_q[2];
	assign active_mask  = active_q;
	assign arrived_mask = arrived_q;

endmodule
`default_nettype wire

// ===== src/three_axis_linear_ramp.sv =====
// Top level of the three-axis linear ramp: sequencer, registers, lanes, output stage.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one frame tick per word: arm and
//   load masks plus load values for x, y, z. Output channel (out_valid/out_stall)
//   returns one word per tick: the three axis values, active and arrived masks.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write targets
//   and frame counts only while no tick is in flight.
// Timing:
//   Each lane runs a restoring divider, one quotient bit per cycle over 25 bits,
//   and that loop sets the rate. A tick passes the prep, divide, step, apply
//   and output states in order, and in_stall stays high until the sequencer is idle again.
//   The output register holds one finished word, so the next tick is taken
//   while that word still waits.
// Reset:
//   arst_n clears all axes to one (Q8.16), idle and unlatched with a zero step;
//   targets reset to one and frame counts to 1. No clearing pass is needed.
// Stall:
//   A stalled output word holds; a finished tick then waits in the lanes
//   and in_stall stays high until the output register frees.
`default_nettype none
module three_axis_linear_ramp (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic [tlr_pkg::AXES-1:0]                 arm_mask,
	input  wire logic [tlr_pkg::AXES-1:0]                 load_mask,
	input  wire logic signed [tlr_pkg::VALUE_BITS-1:0]    load_x,
	input  wire logic signed [tlr_pkg::VALUE_BITS-1:0]    load_y,
	input  wire logic signed [tlr_pkg::VALUE_BITS-1:0]    load_z,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]         value_x,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]         value_y,
	output logic signed [tlr_pkg::VALUE_BITS-1:0]         value_z,
	output logic [tlr_pkg::AXES-1:0]                      active_mask,
	output logic [tlr_pkg::AXES-1:0]                      arrived_mask,
	input  wire logic                                     cfg_we,
	input  wire logic [tlr_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  wire logic [tlr_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

	localparam int VB = tlr_pkg::VALUE_BITS;
	localparam int FB = tlr_pkg::FRAME_BITS;
	localparam int NA = tlr_pkg::AXES;
	localparam int CB = tlr_pkg::CNT_BITS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_DIV   = 6'b000100,
		S_STEP  = 6'b001000,
		S_APPLY = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CB-1:0]            div_cnt_q;
	logic signed [VB-1:0]     target_q [NA];
	logic [FB-1:0]            frames_q [NA];

	logic                     accept;
	logic                     merge_free;
	logic                     merge_load;
	tlr_pkg::tlr_ctl_t        ctl;
	logic signed [VB-1:0]     load_val [NA];
	logic [NA-1:0][VB-1:0]    lane_value;
	logic [NA-1:0]            lane_active;
	logic [NA-1:0]            lane_arrived;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NA; i++) begin
				target_q[i] <= tlr_pkg::VAL_ONE;
				frames_q[i] <= tlr_pkg::FRAMES_RESET;
			end
		end else if (cfg_we) begin
			case (tlr_pkg::tlr_reg_t'(cfg_index))
				tlr_pkg::REG_TARGET_X: target_q[0] <= cfg_data[VB-1:0];
				tlr_pkg::REG_TARGET_Y: target_q[1] <= cfg_data[VB-1:0];
				tlr_pkg::REG_TARGET_Z: target_q[2] <= cfg_data[VB-1:0];
				tlr_pkg::REG_FRAMES_X: frames_q[0] <= cfg_data[FB-1:0];
				tlr_pkg::REG_FRAMES_Y: frames_q[1] <= cfg_data[FB-1:0];
				tlr_pkg::REG_FRAMES_Z: frames_q[2] <= cfg_data[FB-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign merge_load = (state_q == S_OUT) && merge_free;

	// tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_PREP;
				end
				S_PREP: begin
					state_q   <= S_DIV;
					div_cnt_q <= '0;
				end
				S_DIV: begin
					if (div_cnt_q == CB'(tlr_pkg::DIV_BITS - 1)) begin
						state_q <= S_STEP;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				S_STEP:  state_q <= S_APPLY;
				S_APPLY: state_q <= S_OUT;
				S_OUT: begin
					if (merge_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.accept = accept;
		ctl.prep   = (state_q == S_PREP);
		ctl.run    = (state_q == S_DIV);
		ctl.step   = (state_q == S_STEP);
		ctl.apply  = (state_q == S_APPLY);
	end

	assign load_val[0] = load_x;
	assign load_val[1] = load_y;
	assign load_val[2] = load_z;

	// one lane per axis
	for (genvar g = 0; g < NA; g++) begin : g_lane
		tlr_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.arm      (arm_mask[g]),
			.load     (load_mask[g]),
			.load_val (load_val[g]),
			.target   (target_q[g]),
			.frames   (frames_q[g]),
			.value    (lane_value[g]),
			.active   (lane_active[g]),
			.arrived  (lane_arrived[g])
		);
	end

	tlr_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (merge_load),
		.lane_value   (lane_value),
		.lane_active  (lane_active),
		.lane_arrived (lane_arrived),
		.out_stall    (out_stall),
		.free         (merge_free),
		.out_valid    (out_valid),
		.value_x      (value_x),
		.value_y      (value_y),
		.value_z      (value_z),
		.active_mask  (active_mask),
		.arrived_mask (arrived_mask)
	);

	// an axis that arrived on a tick is never reported still active
	a_arrived_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((arrived_mask & active_mask) == '0))
		else $error("axis both arrived and active");

	// an accepted tick always starts the distance capture next
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_PREP))
		else $error("accepted tick did not start");

	// divider runs exactly its bit count
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == CB'(tlr_pkg::DIV_BITS - 1)) |=> (state_q == S_STEP))
		else $error("divider length wrong");

	// a new result word only comes from the output state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result word without finished tick");

endmodule
`default_nettype wire

// ===== tb/tb_three_axis_linear_ramp.sv =====
// Self-checking testbench for the three-axis linear ramp: directed table, then random phases.
module tb_three_axis_linear_ramp;
	timeunit 1ns;
	timeprecision 1ps;

	// spare indexes past the register list; writes there must be ignored
	localparam logic [tlr_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [tlr_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

	localparam longint POS_LIMIT   = (longint'(1) << (tlr_pkg::VALUE_BITS - 1)) - 1;
	localparam longint NEG_LIMIT   = -POS_LIMIT - 1;
	localparam int     CYCLE_LIMIT = 600000;
	localparam int     PHASES      = 8;
	localparam int     PHASE_TICKS = 66;

	typedef struct packed {
		logic [tlr_pkg::AXES-1:0]                          arm;
		logic [tlr_pkg::AXES-1:0]                          load;
		logic [tlr_pkg::AXES-1:0][tlr_pkg::VALUE_BITS-1:0] lv;
	} tick_t;

	typedef struct packed {
		logic [tlr_pkg::AXES-1:0][tlr_pkg::VALUE_BITS-1:0] pos;
		logic [tlr_pkg::AXES-1:0]                          act;
		logic [tlr_pkg::AXES-1:0]                          arr;
	} frame_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		tick_t                              tk;
		bit                                 typed;
		frame_t                             want;
		logic [tlr_pkg::CFG_IDX_BITS-1:0]   idx;
		logic [tlr_pkg::CFG_DATA_BITS-1:0]  data;
	} row_t;

	logic                                   clk       = 1'b0;
	logic                                   arst_n    = 1'b0;
	logic                                   in_valid  = 1'b0;
	logic                                   in_stall;
	logic [tlr_pkg::AXES-1:0]               arm_mask  = '0;
	logic [tlr_pkg::AXES-1:0]               load_mask = '0;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  load_x    = '0;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  load_y    = '0;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  load_z    = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b1;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  value_x;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  value_y;
	logic signed [tlr_pkg::VALUE_BITS-1:0]  value_z;
	logic [tlr_pkg::AXES-1:0]               active_mask;
	logic [tlr_pkg::AXES-1:0]               arrived_mask;
	logic                                   cfg_we    = 1'b0;
	logic [tlr_pkg::CFG_IDX_BITS-1:0]       cfg_index = '0;
	logic [tlr_pkg::CFG_DATA_BITS-1:0]      cfg_data  = '0;

	// shadow of the block: registers and per-axis ramp state
	logic signed [tlr_pkg::VALUE_BITS-1:0]  tgt_reg [tlr_pkg::AXES];
	logic [tlr_pkg::FRAME_BITS-1:0]         nfr_reg [tlr_pkg::AXES];
	logic signed [tlr_pkg::VALUE_BITS-1:0]  axis_pos [tlr_pkg::AXES];
	logic signed [tlr_pkg::VALUE_BITS-1:0]  axis_inc [tlr_pkg::AXES];
	bit                                     axis_locked [tlr_pkg::AXES];
	bit                                     axis_running [tlr_pkg::AXES];

	frame_t pending_frames [$];
	int     errors        = 0;
	int     words_checked = 0;
	int     ticks_sent    = 0;
	int     arrivals      = 0;
	int     settings      = 0;
	int     cycle_count   = 0;
	bit     no_gaps       = 1'b0;

	three_axis_linear_ramp u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.arm_mask     (arm_mask),
		.load_mask    (load_mask),
		.load_x       (load_x),
		.load_y       (load_y),
		.load_z       (load_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value_x      (value_x),
		.value_y      (value_y),
		.value_z      (value_z),
		.active_mask  (active_mask),
		.arrived_mask (arrived_mask),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint mag_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic signed [tlr_pkg::VALUE_BITS-1:0] clamp_value(longint v);
		if (v > POS_LIMIT)
			return POS_LIMIT[tlr_pkg::VALUE_BITS-1:0];
		if (v < NEG_LIMIT)
			return NEG_LIMIT[tlr_pkg::VALUE_BITS-1:0];
		return v[tlr_pkg::VALUE_BITS-1:0];
	endfunction

	// one frame tick: loads, arms, step latch, then stepping per axis
	function automatic frame_t advance_axes(tick_t t);
		frame_t f;
		longint tgt;
		longint cur;
		f = '0;
		for (int a = 0; a < tlr_pkg::AXES; a++) begin
			tgt = longint'(tgt_reg[a]);
			if (t.load[a])
				axis_pos[a] = $signed(t.lv[a]);
			if (t.arm[a]) begin
				axis_running[a] = 1'b1;
				axis_locked[a]  = 1'b0;
			end
			cur = longint'(axis_pos[a]);
			// step is fixed once per arm; zero frames keeps the old one
			if (!axis_locked[a]) begin
				if (axis_running[a]) begin
					if (nfr_reg[a] != '0)
						axis_inc[a] = clamp_value((tgt - cur) / longint'(nfr_reg[a]));
				end else begin
					axis_inc[a] = '0;
				end
				axis_locked[a] = 1'b1;
			end
			if (axis_running[a]) begin
				if (mag_of(tgt - cur) <= mag_of(longint'(axis_inc[a]))) begin
					axis_pos[a]     = tgt_reg[a];
					axis_running[a] = 1'b0;
					f.arr[a]        = 1'b1;
				end else begin
					axis_pos[a] = clamp_value(cur + longint'(axis_inc[a]));
				end
			end
			f.act[a] = axis_running[a];
			f.pos[a] = axis_pos[a];
		end
		return f;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [tlr_pkg::VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return tlr_pkg::VAL_MAX;
			1: return tlr_pkg::VAL_MIN;
			2: return '0;
			3: return tlr_pkg::VAL_ONE;
			default: return tlr_pkg::VALUE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [tlr_pkg::FRAME_BITS-1:0] pick_frames();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return tlr_pkg::FRAME_BITS'(1);
			default: return tlr_pkg::FRAME_BITS'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic row_t mk_tick(logic [tlr_pkg::AXES-1:0] arm,
			logic [tlr_pkg::AXES-1:0] load, logic [tlr_pkg::VALUE_BITS-1:0] x,
			logic [tlr_pkg::VALUE_BITS-1:0] y, logic [tlr_pkg::VALUE_BITS-1:0] z);
		row_t r;
		r = '{kind: ROW_TICK, tk: '0, typed: 1'b0, want: '0, idx: '0, data: '0};
		r.tk.arm   = arm;
		r.tk.load  = load;
		r.tk.lv[0] = x;
		r.tk.lv[1] = y;
		r.tk.lv[2] = z;
		return r;
	endfunction

	function automatic row_t mk_cfg(logic [tlr_pkg::CFG_IDX_BITS-1:0] idx,
			logic [tlr_pkg::CFG_DATA_BITS-1:0] data);
		row_t r;
		r = '{kind: ROW_CFG, tk: '0, typed: 1'b0, want: '0, idx: idx, data: data};
		return r;
	endfunction

	function automatic row_t checked(row_t r, logic [tlr_pkg::VALUE_BITS-1:0] x,
			logic [tlr_pkg::VALUE_BITS-1:0] y, logic [tlr_pkg::VALUE_BITS-1:0] z,
			logic [tlr_pkg::AXES-1:0] act, logic [tlr_pkg::AXES-1:0] arr);
		r.typed      = 1'b1;
		r.want.pos[0] = x;
		r.want.pos[1] = y;
		r.want.pos[2] = z;
		r.want.act   = act;
		r.want.arr   = arr;
		return r;
	endfunction

	// present one tick word, hold it until taken, then log what should come back
	task automatic send_tick(input tick_t t, input bit typed, input frame_t typed_out);
		int gap;
		frame_t pred;
		gap = pick_gap();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		arm_mask  <= t.arm;
		load_mask <= t.load;
		load_x    <= t.lv[0];
		load_y    <= t.lv[1];
		load_z    <= t.lv[2];
		do @(posedge clk); while (in_stall);
		pred = advance_axes(t);
		if (typed)
			pred = typed_out;
		pending_frames.push_back(pred);
		ticks_sent++;
		arrivals += $countones(pred.arr);
	endtask

	// wait for every outstanding word, then a few quiet cycles
	task automatic drain(input int tail);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tlr_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [tlr_pkg::CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tlr_pkg::REG_TARGET_X: tgt_reg[0] = data;
			tlr_pkg::REG_TARGET_Y: tgt_reg[1] = data;
			tlr_pkg::REG_TARGET_Z: tgt_reg[2] = data;
			tlr_pkg::REG_FRAMES_X: nfr_reg[0] = data[tlr_pkg::FRAME_BITS-1:0];
			tlr_pkg::REG_FRAMES_Y: nfr_reg[1] = data[tlr_pkg::FRAME_BITS-1:0];
			tlr_pkg::REG_FRAMES_Z: nfr_reg[2] = data[tlr_pkg::FRAME_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// receiver: random stall runs, compare each taken word with the oldest expectation
	always @(posedge clk) begin : sink
		frame_t want;
		logic   bad;
		int     r;
		static bit stall_now = 1'b1;
		static int run_left  = 0;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: x=%h y=%h z=%h act=%b arr=%b",
						value_x, value_y, value_z, active_mask, arrived_mask);
			end else begin
				want = pending_frames.pop_front();
				words_checked++;
				bad = (value_x !== want.pos[0]) || (value_y !== want.pos[1]) ||
					(value_z !== want.pos[2]) || (active_mask !== want.act) ||
					(arrived_mask !== want.arr);
				if (bad) begin
					errors++;
					if (errors <= 10) begin
						$display("word %0d mismatch: want x=%h y=%h z=%h act=%b arr=%b",
							words_checked, want.pos[0], want.pos[1], want.pos[2],
							want.act, want.arr);
						$display("                 got  x=%h y=%h z=%h act=%b arr=%b",
							value_x, value_y, value_z, active_mask, arrived_mask);
					end
				end
			end
		end
		if (run_left == 0) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				stall_now = 1'b0;
				run_left  = $urandom_range(1, 8);
			end else if (r < 50) begin
				stall_now = 1'b0;
				run_left  = $urandom_range(50, 200);
			end else if (r < 85) begin
				stall_now = 1'b1;
				run_left  = $urandom_range(1, 4);
			end else if (r < 97) begin
				stall_now = 1'b1;
				run_left  = $urandom_range(5, 15);
			end else begin
				stall_now = 1'b1;
				run_left  = $urandom_range(30, 60);
			end
		end else begin
			run_left--;
		end
		out_stall <= stall_now;
	end

	initial begin : stimulus
		row_t   rows [$];
		tick_t  t;
		int     r;
		for (int a = 0; a < tlr_pkg::AXES; a++) begin
			tgt_reg[a]      = tlr_pkg::VAL_ONE;
			nfr_reg[a]      = tlr_pkg::FRAMES_RESET;
			axis_pos[a]     = tlr_pkg::VAL_ONE;
			axis_inc[a]     = '0;
			axis_locked[a]  = 1'b0;
			axis_running[a] = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset, armed on target, loaded extremes, one-frame ramps
		rows.push_back(checked(mk_tick(3'b000, 3'b000, '0, '0, '0),
			tlr_pkg::VAL_ONE, tlr_pkg::VAL_ONE, tlr_pkg::VAL_ONE, 3'b000, 3'b000));
		rows.push_back(checked(mk_tick(3'b111, 3'b000, '0, '0, '0),
			tlr_pkg::VAL_ONE, tlr_pkg::VAL_ONE, tlr_pkg::VAL_ONE, 3'b000, 3'b111));
		rows.push_back(checked(mk_tick(3'b000, 3'b111, tlr_pkg::VAL_MAX, tlr_pkg::VAL_MIN, '0),
			tlr_pkg::VAL_MAX, tlr_pkg::VAL_MIN, '0, 3'b000, 3'b000));
		// y step overflows here and saturates
		rows.push_back(mk_tick(3'b111, 3'b000, '0, '0, '0));
		rows.push_back(mk_tick(3'b000, 3'b000, '1, '1, '1));
		// extreme targets, full-scale distance on x
		rows.push_back(mk_cfg(tlr_pkg::REG_TARGET_X, tlr_pkg::VAL_MAX));
		rows.push_back(mk_cfg(tlr_pkg::REG_TARGET_Y, tlr_pkg::VAL_MIN));
		rows.push_back(mk_cfg(tlr_pkg::REG_TARGET_Z, '0));
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_X, tlr_pkg::CFG_DATA_BITS'(1)));
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_Y, tlr_pkg::CFG_DATA_BITS'(4095)));
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_Z, tlr_pkg::CFG_DATA_BITS'(2)));
		rows.push_back(mk_tick(3'b111, 3'b111, tlr_pkg::VAL_MIN, tlr_pkg::VAL_MAX, 24'd100));
		rows.push_back(mk_tick(3'b000, 3'b000, '0, '0, '0));
		rows.push_back(mk_tick(3'b000, 3'b000, '0, '0, '0));
		rows.push_back(mk_tick(3'b000, 3'b000, '0, '0, '0));
		// zero frames via masked data: z keeps its old step, pointed away, and clamps
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_Z, 24'hFFF000));
		rows.push_back(mk_tick(3'b100, 3'b100, '0, '0, 24'h80000A));
		rows.push_back(mk_tick(3'b000, 3'b000, '0, '0, '0));
		rows.push_back(mk_cfg(REG_SPARE_A, tlr_pkg::CFG_DATA_BITS'($urandom())));
		rows.push_back(mk_cfg(REG_SPARE_B, tlr_pkg::CFG_DATA_BITS'($urandom())));
		// truncated step of zero never arrives
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_X, tlr_pkg::CFG_DATA_BITS'(4095)));
		rows.push_back(mk_tick(3'b001, 3'b001, 24'h7FFF9B, '0, '0));
		rows.push_back(mk_tick(3'b000, 3'b000, '0, '0, '0));
		rows.push_back(mk_cfg(tlr_pkg::REG_FRAMES_X, '0));
		rows.push_back(mk_tick(3'b001, 3'b010, '0, '0, '0));
		rows.push_back(mk_tick(3'b000, 3'b111, 24'h123456, 24'hEDCBA9, 24'h555555));
		rows.push_back(mk_tick(3'b111, 3'b000, 24'hAAAAAA, '0, '0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain(4);
				write_reg(rows[i].idx, rows[i].data);
				settings++;
			end else begin
				send_tick(rows[i].tk, rows[i].typed, rows[i].want);
			end
		end

		// random phases: new settings, then ramps started, run out and disturbed
		for (int p = 0; p < PHASES; p++) begin
			drain(4);
			write_reg(tlr_pkg::REG_TARGET_X, pick_value());
			write_reg(tlr_pkg::REG_TARGET_Y, pick_value());
			write_reg(tlr_pkg::REG_TARGET_Z, pick_value());
			write_reg(tlr_pkg::REG_FRAMES_X, tlr_pkg::CFG_DATA_BITS'(pick_frames()) |
				tlr_pkg::CFG_DATA_BITS'($urandom() << tlr_pkg::FRAME_BITS));
			write_reg(tlr_pkg::REG_FRAMES_Y, tlr_pkg::CFG_DATA_BITS'(pick_frames()));
			write_reg(tlr_pkg::REG_FRAMES_Z, tlr_pkg::CFG_DATA_BITS'(pick_frames()));
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
				tlr_pkg::CFG_DATA_BITS'($urandom()));
			settings++;
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_TICKS; k++) begin
				r = $urandom_range(0, 99);
				t.lv[0] = pick_value();
				t.lv[1] = pick_value();
				t.lv[2] = pick_value();
				if (r < 15) begin
					t.arm  = tlr_pkg::AXES'($urandom_range(1, 7));
					t.load = t.arm & tlr_pkg::AXES'($urandom());
				end else if (r < 25) begin
					t.arm  = tlr_pkg::AXES'($urandom_range(0, 7));
					t.load = tlr_pkg::AXES'($urandom_range(0, 7));
				end else begin
					t.arm  = '0;
					t.load = '0;
				end
				send_tick(t, 1'b0, '0);
			end
		end
		no_gaps = 1'b0;

		drain(40);
		$display("Sent %0d frame ticks across %0d register settings, %0d words checked,",
			ticks_sent, settings, words_checked);
		$display("%0d axis arrivals expected, %0d failures.", arrivals, errors);
		if (errors == 0 && pending_frames.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
